[design/flru_pkg.sv]
// ----------------------------------------------------------------------------
// flru_pkg: shared types and constants for the factoradic LRU rank update
// Field widths, stream packing and the factorial helper used at elaboration.
// ----------------------------------------------------------------------------
package flru_pkg;

	localparam int DEF_WAYS = 10;
	localparam int RANK_W   = 22;
	localparam int WAY_W    = 4;
	localparam int MASK_W   = 10;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 32;

	// item fields that ride along the pipeline with each beat
	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic [WAY_W-1:0]  touch;
		logic [MASK_W-1:0] mask;
		logic              err;
		logic              seen;  // touched way already passed in the order
	} flru_item_t;

	function automatic logic [31:0] fact(input int n);
		logic [31:0] f;
		f = 32'd1;
		for (int i = 2; i <= n; i++) begin
			f = f * 32'(i);
		end
		return f;
	endfunction

endpackage

[design/factoradic_lru_rank_update.sv]
// ----------------------------------------------------------------------------
// factoradic_lru_rank_update: true-LRU step for one cache set
// Unranks the set's Lehmer-coded recency order, picks the victim among the
// candidate ways, moves the touched way to the front and re-ranks it.
// ----------------------------------------------------------------------------
// Pipeline: one digit stage per order position, then the result register.
// Throughput: one beat per cycle; the whole pipe advances together and
//   holds only while the result register is full and the sink stalls.
// Reset: arst_n clears the stage valid bits and the result valid; the
//   payload registers are not reset.
// ----------------------------------------------------------------------------
module factoradic_lru_rank_update #(
	parameter int WAYS = flru_pkg::DEF_WAYS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// slave side
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [21:0] current_rank, [25:22] touch_way, [35:26] candidate_mask, rest zero
	input  logic [flru_pkg::S_DATA_W-1:0] s_tdata,
	// master side
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [21:0] new_rank, [25:22] victim_way, [26] victim_found, [27] rank_error
	output logic [flru_pkg::M_DATA_W-1:0] m_tdata
);

	localparam int IDX_W = $clog2(WAYS);
	localparam logic [31:0] FACT_W = flru_pkg::fact(WAYS);
	localparam int ACC_W = $clog2(FACT_W);

	// stall everything when the result beat is still waiting
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// stage links: index 0 is the incoming beat, index k the output of stage k-1
	logic                                 valid_c [WAYS+1];
	flru_pkg::flru_item_t                 item_c  [WAYS+1];
	logic [flru_pkg::RANK_W-1:0]          rem_c   [WAYS+1];
	logic [WAYS-1:0][flru_pkg::WAY_W-1:0] avail_c [WAYS+1];
	logic [WAYS-1:0][flru_pkg::WAY_W-1:0] order_c [WAYS+1];
	logic [ACC_W-1:0]                     acc_c   [WAYS+1];
	logic [IDX_W-1:0]                     pdig_c  [WAYS+1];
	logic [flru_pkg::WAY_W-1:0]           pway_c  [WAYS+1];

	always_comb begin
		valid_c[0]       = s_tvalid;
		item_c[0].rank   = s_tdata[flru_pkg::RANK_W-1:0];
		item_c[0].touch  = s_tdata[flru_pkg::RANK_W +: flru_pkg::WAY_W];
		item_c[0].mask   = s_tdata[flru_pkg::RANK_W + flru_pkg::WAY_W +: flru_pkg::MASK_W];
		// out-of-range rank: flagged here, result passes rank through
		item_c[0].err    = 32'(item_c[0].rank) >= FACT_W;
		item_c[0].seen   = 1'b0;
		rem_c[0]         = item_c[0].rank;
		for (int j = 0; j < WAYS; j++) begin
			avail_c[0][j] = flru_pkg::WAY_W'(j);
		end
		order_c[0] = '0;
		acc_c[0]   = '0;
		pdig_c[0]  = '0;
		pway_c[0]  = '0;
	end

	for (genvar k = 0; k < WAYS; k++) begin : g_stage
		flru_digit_stage #(
			.WAYS  (WAYS),
			.POS   (k),
			.ACC_W (ACC_W)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (valid_c[k]),
			.in_item   (item_c[k]),
			.rem_i     (rem_c[k]),
			.avail_i   (avail_c[k]),
			.order_i   (order_c[k]),
			.acc_i     (acc_c[k]),
			.pdig_i    (pdig_c[k]),
			.pway_i    (pway_c[k]),
			.out_valid (valid_c[k+1]),
			.out_item  (item_c[k+1]),
			.rem_o     (rem_c[k+1]),
			.avail_o   (avail_c[k+1]),
			.order_o   (order_c[k+1]),
			.acc_o     (acc_c[k+1]),
			.pdig_o    (pdig_c[k+1]),
			.pway_o    (pway_c[k+1])
		);
	end

	// remainder and free list are spent by the last stage
	flru_finish #(
		.WAYS  (WAYS),
		.ACC_W (ACC_W)
	) u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (valid_c[WAYS]),
		.in_item   (item_c[WAYS]),
		.order_i   (order_c[WAYS]),
		.acc_i     (acc_c[WAYS]),
		.pdig_i    (pdig_c[WAYS]),
		.pway_i    (pway_c[WAYS]),
		.out_valid (m_tvalid),
		.out_data  (m_tdata)
	);

endmodule

[design/flru_digit_stage.sv]
// ----------------------------------------------------------------------------
// flru_digit_stage: one position of the recency order
// Peels off one factoradic digit, picks that way from the free list, and
// adds the re-rank term of the previous position to the running sum.
// ----------------------------------------------------------------------------
module flru_digit_stage #(
	parameter int WAYS  = flru_pkg::DEF_WAYS,
	parameter int POS   = 0,
	parameter int ACC_W = 22
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      adv,
	input  logic                                      in_valid,
	input  flru_pkg::flru_item_t                      in_item,
	input  logic [flru_pkg::RANK_W-1:0]               rem_i,
	input  logic [WAYS-1:0][flru_pkg::WAY_W-1:0]      avail_i,
	input  logic [WAYS-1:0][flru_pkg::WAY_W-1:0]      order_i,
	input  logic [ACC_W-1:0]                          acc_i,
	input  logic [$clog2(WAYS)-1:0]                   pdig_i,
	input  logic [flru_pkg::WAY_W-1:0]                pway_i,
	output logic                                      out_valid,
	output flru_pkg::flru_item_t                      out_item,
	output logic [flru_pkg::RANK_W-1:0]               rem_o,
	output logic [WAYS-1:0][flru_pkg::WAY_W-1:0]      avail_o,
	output logic [WAYS-1:0][flru_pkg::WAY_W-1:0]      order_o,
	output logic [ACC_W-1:0]                          acc_o,
	output logic [$clog2(WAYS)-1:0]                   pdig_o,
	output logic [flru_pkg::WAY_W-1:0]                pway_o
);

	localparam int IDX_W = $clog2(WAYS);
	localparam bit HAS_PREV = (POS > 0);
	localparam int PP = POS - 1;
	localparam logic [31:0] F  = flru_pkg::fact(WAYS - 1 - POS);
	localparam logic [31:0] W1 = flru_pkg::fact(WAYS - 1);
	localparam logic [31:0] WP = flru_pkg::fact(WAYS - 1 - PP);
	localparam logic [31:0] WQ = (WAYS - 2 - PP >= 0) ? flru_pkg::fact(WAYS - 2 - PP) : 32'd0;

	logic [IDX_W-1:0]                   dig;
	logic [flru_pkg::WAY_W-1:0]         way;
	logic [WAYS-1:0][flru_pkg::WAY_W-1:0] avail_n;
	logic [WAYS-1:0][flru_pkg::WAY_W-1:0] order_n;
	logic [ACC_W-1:0]                   term;
	logic                               hit_prev;
	logic                               lt;
	flru_pkg::flru_item_t               item_n;

	logic                               valid_s1;
	flru_pkg::flru_item_t               item_s1;
	logic [flru_pkg::RANK_W-1:0]        rem_s1;
	logic [WAYS-1:0][flru_pkg::WAY_W-1:0] avail_s1;
	logic [WAYS-1:0][flru_pkg::WAY_W-1:0] order_s1;
	logic [ACC_W-1:0]                   acc_s1;
	logic [IDX_W-1:0]                   dig_s1;
	logic [flru_pkg::WAY_W-1:0]         way_s1;

	// digit = number of multiples of the weight that fit in the remainder
	always_comb begin
		dig = '0;
		for (int j = 1; j < WAYS - POS; j++) begin
			if (32'(rem_i) >= 32'(j) * F) begin
				dig = IDX_W'(j);
			end
		end
	end

	always_comb begin
		way = avail_i[dig];
		for (int j = 0; j < WAYS - 1; j++) begin
			avail_n[j] = (IDX_W'(j) < dig) ? avail_i[j] : avail_i[j+1];
		end
		avail_n[WAYS-1] = avail_i[WAYS-1];
		order_n = order_i;
		order_n[POS] = way;
	end

	// re-rank term of the previous position after the touched way moves up
	always_comb begin
		hit_prev = HAS_PREV && (pway_i == in_item.touch);
		lt = (in_item.touch < pway_i);
		if (!HAS_PREV) begin
			term = '0;
		end else if (hit_prev) begin
			term = ACC_W'(32'(in_item.touch) * W1);
		end else if (in_item.seen) begin
			term = ACC_W'(32'(pdig_i) * WP);
		end else begin
			term = ACC_W'(32'(pdig_i - IDX_W'(lt)) * WQ);
		end
		item_n      = in_item;
		item_n.seen = in_item.seen | hit_prev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1  <= item_n;
			rem_s1   <= flru_pkg::RANK_W'(32'(rem_i) - 32'(dig) * F);
			avail_s1 <= avail_n;
			order_s1 <= order_n;
			acc_s1   <= acc_i + term;
			dig_s1   <= dig;
			way_s1   <= way;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;
	assign rem_o     = rem_s1;
	assign avail_o   = avail_s1;
	assign order_o   = order_s1;
	assign acc_o     = acc_s1;
	assign pdig_o    = dig_s1;
	assign pway_o    = way_s1;

endmodule

[design/flru_finish.sv]
// ----------------------------------------------------------------------------
// flru_finish: victim pick and result register
// Closes the re-rank sum, scans the order for the least recent candidate,
// and holds the result beat until the sink takes it.
// ----------------------------------------------------------------------------
module flru_finish #(
	parameter int WAYS  = flru_pkg::DEF_WAYS,
	parameter int ACC_W = 22
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  logic                                 in_valid,
	input  flru_pkg::flru_item_t                 in_item,
	input  logic [WAYS-1:0][flru_pkg::WAY_W-1:0] order_i,
	input  logic [ACC_W-1:0]                     acc_i,
	input  logic [$clog2(WAYS)-1:0]              pdig_i,
	input  logic [flru_pkg::WAY_W-1:0]           pway_i,
	output logic                                 out_valid,
	output logic [flru_pkg::M_DATA_W-1:0]        out_data
);

	localparam int RES_W = flru_pkg::RANK_W + flru_pkg::WAY_W + 2;
	localparam logic [31:0] W1 = flru_pkg::fact(WAYS - 1);

	logic [ACC_W-1:0]            term;
	logic [ACC_W-1:0]            acc_n;
	logic [flru_pkg::RANK_W-1:0] rank_n;
	logic [flru_pkg::WAY_W-1:0]  vic;
	logic                        found;
	logic                        touch_ok;

	logic                        valid_q;
	logic [flru_pkg::RANK_W-1:0] rank_q;
	logic [flru_pkg::WAY_W-1:0]  vic_q;
	logic                        found_q;
	logic                        err_q;

	// last position: weight 0! on its own digit (always zero), none if shifted
	always_comb begin
		if (pway_i == in_item.touch) begin
			term = ACC_W'(32'(in_item.touch) * W1);
		end else if (in_item.seen) begin
			term = ACC_W'(pdig_i);
		end else begin
			term = '0;
		end
		acc_n    = acc_i + term;
		touch_ok = 32'(in_item.touch) < 32'(WAYS);
		rank_n   = (in_item.err || !touch_ok) ? in_item.rank : flru_pkg::RANK_W'(acc_n);
	end

	// later positions win: the last hit is the least recent candidate
	always_comb begin
		vic   = '0;
		found = 1'b0;
		for (int i = 0; i < WAYS; i++) begin
			if ((32'(order_i[i]) < 32'(flru_pkg::MASK_W)) && in_item.mask[order_i[i]]) begin
				vic   = order_i[i];
				found = 1'b1;
			end
		end
		if (in_item.err) begin
			vic   = '0;
			found = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rank_q  <= rank_n;
			vic_q   <= vic;
			found_q <= found;
			err_q   <= in_item.err;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = {{(flru_pkg::M_DATA_W - RES_W){1'b0}}, err_q, found_q, vic_q, rank_q};

endmodule
